### hdl/ecg_beat_rate_meter_defines.svh
// Assertion macros used by the checker of the ECG beat rate meter.
`ifndef ECG_BEAT_RATE_METER_DEFINES_SVH
`define ECG_BEAT_RATE_METER_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while rst_n is low.
`define EBRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, ignored while rst_n is low.
`define EBRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ebrm_pkg.sv
// Package with types, constants and control structs of the ECG beat rate meter.
`timescale 1ns / 1ps

package ebrm_pkg;

  localparam int RING_DEPTH_DEF = 50;

  localparam int TICK_W  = 32;
  localparam int LEVEL_W = 12;
  localparam int THR_W   = 12;
  localparam int REFR_W  = 16;
  localparam int WIN_W   = 20;
  localparam int TPM_W   = 16;
  localparam int RATE_W  = 16;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_ADDR_W-1:0] CFG_BEAT_THRESHOLD   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REFRACTORY_TICKS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_TICKS     = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TICKS_PER_MINUTE = 2'd3;

  localparam logic [THR_W-1:0]  THR_RESET  = 12'd500;
  localparam logic [REFR_W-1:0] REFR_RESET = 16'd50;
  localparam logic [WIN_W-1:0]  WIN_RESET  = 20'd1000;
  localparam logic [TPM_W-1:0]  TPM_RESET  = 16'd6000;

  localparam logic [RATE_W-1:0] RATE_SAT = 16'hFFFF;

  typedef struct packed {
    logic [TICK_W-1:0]  sample_tick;
    logic [LEVEL_W-1:0] sample_level;
  } in_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] beat_tick;
    logic [RATE_W-1:0] rate_bpm;
    logic              rate_valid;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic write_pend;
    logic drop_pend;
    logic rd_oldest;
    logic purge_step;
    logic commit;
    logic span_cap;
    logic mul_load;
    logic div_start;
    logic rate_clear;
    logic out_load;
  } ebrm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_low;
    logic open;
    logic ring_empty;
    logic refr_drop;
    logic purge_hit;
    logic rate_ok;
    logic div_done;
    logic out_free;
  } ebrm_stat_t;

endpackage

### hdl/ecg_beat_rate_meter.sv
// Top level of the ECG beat rate meter: controller plus datapath.
`timescale 1ns / 1ps
//
// The block takes timed ECG samples on the in_ channel (valid/ready, one
// sample per transfer) and produces one result per committed beat on the
// out_ channel: the tick of the committing sample, the rate in beats per
// minute and a flag that tells whether the rate means anything.
// The user must write the four settings through cfg_we/cfg_addr/cfg_wdata
// while the block is idle, which the block itself does not enforce; each write
// takes effect at the clock edge that carries it. A sample that does not
// commit a beat returns the controller to idle from the check state.
// A committing sample goes on through the purge walk, which reads the stored
// stamps one at a time from the stamp memory, then the commit and the rate
// computation, in which the divider retires one quotient bit a cycle.
// Samples are handled one at a time: in_ready is high only while the
// controller waits for a sample. A finished result sits in the output
// register, so the next sample is taken while the receiver stalls; only a
// second result waits until the first one has been transferred.
// Synchronous reset returns the settings to their defaults, empties the
// ring and drops any pending beat. The stamp memory needs no clearing pass.
//
module ecg_beat_rate_meter import ebrm_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  ebrm_cmd_t  cmd;
  ebrm_stat_t stat;

  // The controller walks each sample through check, purge, commit and the
  // rate computation, issuing one command set per cycle.
  ebrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the ring of beat stamps, the settings, the divider
  // and the output register.
  ebrm_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### hdl/ebrm_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module ebrm_div import ebrm_pkg::*; #(
  parameter int NUM_W = TPM_W + 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [TICK_W-1:0] den,
  output logic              done,
  output logic [NUM_W-1:0]  quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TICK_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [TICK_W:0]   trial;
  logic [TICK_W:0]   diff;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(NUM_W);
      rem_nxt  = '0;
      quo_nxt  = num;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = diff[TICK_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[TICK_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### hdl/ebrm_ctrl.sv
// Controller state machine that sequences one sample through the datapath.
`timescale 1ns / 1ps

module ebrm_ctrl import ebrm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ebrm_stat_t stat,
  output ebrm_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_PURGE_RD  = 4'd2;
  localparam logic [3:0] S_PURGE_CHK = 4'd3;
  localparam logic [3:0] S_COMMIT    = 4'd4;
  localparam logic [3:0] S_SPAN_RD   = 4'd5;
  localparam logic [3:0] S_SPAN_CAP  = 4'd6;
  localparam logic [3:0] S_MUL       = 4'd7;
  localparam logic [3:0] S_DIV_GO    = 4'd8;
  localparam logic [3:0] S_DIV       = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_low) begin
          cmd.write_pend = !stat.open;
          state_nxt      = S_IDLE;
        end else if (!stat.open) begin
          state_nxt = S_IDLE;
        end else if (!stat.ring_empty && stat.refr_drop) begin
          cmd.drop_pend = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_PURGE_RD;
        end
      end
      S_PURGE_RD: begin
        if (stat.ring_empty) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.rd_oldest = 1'b1;
          state_nxt     = S_PURGE_CHK;
        end
      end
      S_PURGE_CHK: begin
        if (stat.purge_hit) begin
          cmd.purge_step = 1'b1;
          state_nxt      = S_PURGE_RD;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_SPAN_RD;
      end
      S_SPAN_RD: begin
        cmd.rd_oldest = 1'b1;
        state_nxt     = S_SPAN_CAP;
      end
      S_SPAN_CAP: begin
        cmd.span_cap = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        if (stat.rate_ok) begin
          cmd.mul_load = 1'b1;
          state_nxt    = S_DIV_GO;
        end else begin
          cmd.rate_clear = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/ebrm_dp.sv
// Datapath: configuration registers, stamp ring, pointers, rate arithmetic and output register.
`timescale 1ns / 1ps

module ebrm_dp import ebrm_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_data,
  input  ebrm_cmd_t             cmd,
  input  logic                  out_ready,
  output ebrm_stat_t            stat,
  output logic                  out_valid,
  output out_item_t             out_data
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = PTR_W;
  localparam int NUM_W = TPM_W + CNT_W;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  // Configuration.
  logic [THR_W-1:0]  thr_r;
  logic [REFR_W-1:0] refr_r;
  logic [WIN_W-1:0]  win_r;
  logic [TPM_W-1:0]  tpm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      refr_r <= REFR_RESET;
      win_r  <= WIN_RESET;
      tpm_r  <= TPM_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BEAT_THRESHOLD:   thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_REFRACTORY_TICKS: refr_r <= cfg_wdata[REFR_W-1:0];
        CFG_WINDOW_TICKS:     win_r  <= cfg_wdata[WIN_W-1:0];
        CFG_TICKS_PER_MINUTE: tpm_r  <= cfg_wdata[TPM_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring control state.
  logic [PTR_W-1:0] oldest_ptr_r, oldest_ptr_nxt;
  logic [PTR_W-1:0] pend_ptr_r, pend_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             open_r, open_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [TICK_W-1:0]  tick_r;
  logic [LEVEL_W-1:0] level_r;
  logic [TICK_W-1:0]  pend_stamp_r;
  logic [TICK_W-1:0]  last_stamp_r;
  logic [TICK_W-1:0]  rd_data_r;
  logic [TICK_W-1:0]  span_r;
  logic [NUM_W-1:0]   num_r;
  logic [RATE_W-1:0]  rate_r;
  logic               rval_r;
  out_item_t          out_data_r;

  logic [TICK_W-1:0] ring_mem [RING_DEPTH];

  logic [TICK_W-1:0] gap;
  logic [TICK_W-1:0] age;
  logic              div_done;
  logic [NUM_W-1:0]  quo;

  always_ff @(posedge clk) begin
    if (cmd.write_pend) begin
      ring_mem[pend_ptr_r] <= tick_r;
    end
    if (cmd.rd_oldest) begin
      rd_data_r <= ring_mem[oldest_ptr_r];
    end
  end

  assign gap = pend_stamp_r - last_stamp_r;
  assign age = tick_r - rd_data_r;

  always_comb begin
    oldest_ptr_nxt = oldest_ptr_r;
    pend_ptr_nxt   = pend_ptr_r;
    count_nxt      = count_r;
    open_nxt       = open_r;
    if (cmd.write_pend) begin
      open_nxt = 1'b1;
    end
    if (cmd.drop_pend) begin
      open_nxt = 1'b0;
    end
    if (cmd.purge_step) begin
      oldest_ptr_nxt = ptr_inc(oldest_ptr_r);
      count_nxt      = count_r - 1'b1;
    end
    if (cmd.commit) begin
      pend_ptr_nxt = ptr_inc(pend_ptr_r);
      open_nxt     = 1'b0;
      if (count_r == FULL_CNT) begin
        oldest_ptr_nxt = ptr_inc(oldest_ptr_r);
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_ptr_r <= '0;
      pend_ptr_r   <= '0;
      count_r      <= '0;
      open_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      oldest_ptr_r <= oldest_ptr_nxt;
      pend_ptr_r   <= pend_ptr_nxt;
      count_r      <= count_nxt;
      open_r       <= open_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tick_r  <= in_data.sample_tick;
      level_r <= in_data.sample_level;
    end
    if (cmd.write_pend) begin
      pend_stamp_r <= tick_r;
    end
    if (cmd.commit) begin
      last_stamp_r <= pend_stamp_r;
    end
    if (cmd.span_cap) begin
      span_r <= last_stamp_r - rd_data_r;
    end
    if (cmd.mul_load) begin
      num_r <= NUM_W'(tpm_r) * NUM_W'(count_r - 1'b1);
    end
    if (cmd.rate_clear) begin
      rate_r <= '0;
      rval_r <= 1'b0;
    end else if (div_done) begin
      rate_r <= (|quo[NUM_W-1:RATE_W]) ? RATE_SAT : quo[RATE_W-1:0];
      rval_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_data_r.beat_tick  <= tick_r;
      out_data_r.rate_bpm   <= rate_r;
      out_data_r.rate_valid <= rval_r;
    end
  end

  ebrm_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (span_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    stat.is_low     = (level_r <= thr_r);
    stat.open       = open_r;
    stat.ring_empty = (count_r == '0);
    stat.refr_drop  = (gap <= TICK_W'(refr_r));
    stat.purge_hit  = (age > TICK_W'(win_r));
    stat.rate_ok    = (count_r > CNT_W'(1)) && (span_r != '0);
    stat.div_done   = div_done;
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/ebrm_checker.sv
// Port-level checker for the ECG beat rate meter and its bind statement.
`timescale 1ns / 1ps
`include "ecg_beat_rate_meter_defines.svh"

module ebrm_checker import ebrm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result keeps its value.
  `EBRM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // Samples are taken one at a time.
  `EBRM_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "sample taken while busy")

  // No result can appear in the cycle right after a sample transfer.
  `EBRM_ASSERT_NXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result too early")

  // An invalid rate reads as zero.
  `EBRM_ASSERT_IMP(a_invalid_rate_zero, out_valid && !out_data.rate_valid, out_data.rate_bpm == '0, "invalid rate not zero")

endmodule

bind ecg_beat_rate_meter ebrm_checker u_chk (.*);
